// ----- src/plet_pkg.sv -----
// shared types, constants and the per-character parse function for the pyx line tokenizer
// no dependencies; used by the interfaces and every module of the block
package plet_pkg;

   // sizes
   localparam int SEGMENT_MAX = 8192;
   localparam int ATTR_MAX    = 64;
   localparam int SEG_W       = $clog2(SEGMENT_MAX);
   localparam int ATTR_W      = $clog2(ATTR_MAX);
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = SEG_W;

   localparam logic [SEG_W-1:0]  SEG_CAP  = SEG_W'(SEGMENT_MAX - 1);
   localparam logic [ATTR_W-1:0] ATTR_CAP = ATTR_W'(ATTR_MAX - 1);

   // characters that steer the parse
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NL     = 8'h0A;

   typedef enum logic [3:0] {
      LK_NONE    = 4'd0,
      LK_COMMENT = 4'd1,
      LK_PI      = 4'd2,
      LK_DECL    = 4'd3,
      LK_DATA    = 4'd4,
      LK_ATTR    = 4'd5,
      LK_START   = 4'd6,
      LK_END     = 4'd7,
      LK_UNKNOWN = 4'd8
   } line_kind_type;

   typedef enum logic [1:0] {
      PH_SOL = 2'd0,
      PH_KEY = 2'd1,
      PH_VAL = 2'd2
   } line_phase_type;

   typedef enum logic [2:0] {
      EV_CONTENT    = 3'd0,
      EV_START_ELEM = 3'd1,
      EV_END_ELEM   = 3'd2,
      EV_DATA_END   = 3'd3,
      EV_PI_END     = 3'd4,
      EV_COMMENT_END = 3'd5,
      EV_ATTR_END   = 3'd6
   } event_kind_type;

   typedef enum logic [2:0] {
      PT_START_NAME = 3'd0,
      PT_END_NAME   = 3'd1,
      PT_ATTR_KEY   = 3'd2,
      PT_ATTR_VALUE = 3'd3,
      PT_DATA       = 3'd4,
      PT_PI_TARGET  = 3'd5,
      PT_PI_DATA    = 3'd6,
      PT_COMMENT    = 3'd7
   } content_part_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SEGMENT_LIMIT   = 1'b0,
      REG_ATTRIBUTE_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      line_kind_type       line_kind;
      line_phase_type      line_phase;
      logic                escape_pending;
      logic [SEG_W-1:0]    segment_length;
      logic [ATTR_W-1:0]   attribute_count;
   } parse_state_type;

   typedef struct packed {
      event_kind_type      event_kind;
      content_part_type    content_part;
      logic [7:0]          content_byte;
      logic [ATTR_W-1:0]   attr_total;
   } result_type;

   // one accepted byte's results: one, or two when the pair flag is set
   typedef struct packed {
      logic                pair;
      result_type          first;
      result_type          second;
   } bundle_type;

   typedef struct packed {
      parse_state_type     st;
      logic                hit;
      result_type          res;
   } char_step_type;

   // one character through the line parser; at most one result per character
   function automatic char_step_type take_char(parse_state_type s, logic [7:0] c_raw,
                                               logic [SEG_W-1:0] seg_limit,
                                               logic [ATTR_W-1:0] attr_limit);
      char_step_type    r;
      logic [7:0]       c;
      content_part_type part;
      logic             keep;
      logic [SEG_W-1:0] slim;
      logic [ATTR_W-1:0] alim;
      r     = '0;
      r.st  = s;
      c     = c_raw;
      part  = PT_START_NAME;
      keep  = 1'b0;
      slim  = (seg_limit > SEG_CAP) ? SEG_CAP : seg_limit;
      alim  = (attr_limit > ATTR_CAP) ? ATTR_CAP : attr_limit;

      if (c == CH_NL && s.line_phase != PH_SOL) begin
         // line end: emit the kind's end event
         unique case (s.line_kind)
            LK_END: begin
               r.hit = 1'b1;
               r.res.event_kind = EV_END_ELEM;
            end
            LK_ATTR: begin
               if (s.attribute_count < alim)
                  r.st.attribute_count = s.attribute_count + 1'b1;
               r.hit = 1'b1;
               r.res.event_kind = EV_ATTR_END;
            end
            LK_DATA: begin
               r.hit = 1'b1;
               r.res.event_kind = EV_DATA_END;
            end
            LK_PI: begin
               r.hit = 1'b1;
               r.res.event_kind = EV_PI_END;
            end
            LK_COMMENT: begin
               r.hit = 1'b1;
               r.res.event_kind = EV_COMMENT_END;
            end
            default: ;
         endcase
         r.st.segment_length = '0;
         r.st.line_phase = PH_SOL;
      end else if (s.line_phase == PH_SOL) begin
         // first character picks the line kind; a pending start element goes out
         r.st.segment_length = '0;
         if ((s.line_kind == LK_START || s.line_kind == LK_ATTR) && c != CH_A) begin
            r.hit = 1'b1;
            r.res.event_kind = EV_START_ELEM;
            r.res.attr_total = s.attribute_count;
         end
         unique case (c)
            CH_LPAREN: begin
               r.st.line_kind = LK_START;
               r.st.attribute_count = '0;
            end
            CH_RPAREN: r.st.line_kind = LK_END;
            CH_A:      r.st.line_kind = LK_ATTR;
            CH_DASH:   r.st.line_kind = LK_DATA;
            CH_C:      r.st.line_kind = LK_COMMENT;
            CH_D:      r.st.line_kind = LK_DECL;
            CH_QUEST:  r.st.line_kind = LK_PI;
            default:   r.st.line_kind = LK_UNKNOWN;
         endcase
         r.st.line_phase = PH_KEY;
      end else if (!s.escape_pending && c == CH_BSLASH) begin
         r.st.escape_pending = 1'b1;
      end else begin
         // content position, with escape translation
         if (s.escape_pending) begin
            r.st.escape_pending = 1'b0;
            if (c == CH_N)
               c = CH_NL;
         end
         unique case (s.line_kind)
            LK_ATTR, LK_PI: begin
               if (s.line_phase == PH_KEY && c == CH_SPACE) begin
                  r.st.segment_length = '0;
                  r.st.line_phase = PH_VAL;
               end else if (s.line_phase == PH_KEY) begin
                  keep = 1'b1;
                  part = (s.line_kind == LK_ATTR) ? PT_ATTR_KEY : PT_PI_TARGET;
               end else begin
                  keep = 1'b1;
                  part = (s.line_kind == LK_ATTR) ? PT_ATTR_VALUE : PT_PI_DATA;
               end
            end
            LK_START: begin
               keep = 1'b1;
               part = PT_START_NAME;
            end
            LK_END: begin
               keep = 1'b1;
               part = PT_END_NAME;
            end
            LK_DATA: begin
               keep = 1'b1;
               part = PT_DATA;
            end
            LK_COMMENT: begin
               keep = 1'b1;
               part = PT_COMMENT;
            end
            default: ;
         endcase
         if (keep && s.segment_length < slim) begin
            r.st.segment_length = s.segment_length + 1'b1;
            r.hit = 1'b1;
            r.res.event_kind = EV_CONTENT;
            r.res.content_part = part;
            r.res.content_byte = c;
         end
      end
      return r;
   endfunction

endpackage

// ----- src/plet_if.sv -----
// valid/ready channel interfaces for the pyx line tokenizer: input bytes, results, csr writes
// depends on plet_pkg for field widths
interface plet_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       is_final;

   modport source (output valid, byte_value, is_final, input ready);
   modport sink (input valid, byte_value, is_final, output ready);
endinterface

interface plet_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  event_kind;
   logic [2:0]                  content_part;
   logic [7:0]                  content_byte;
   logic [plet_pkg::ATTR_W-1:0] attr_total;
   logic                        last_result;

   modport source (output valid, event_kind, content_part, content_byte, attr_total,
                   last_result, input ready);
   modport sink (input valid, event_kind, content_part, content_byte, attr_total,
                 last_result, output ready);
endinterface

interface plet_csr_if;
   logic                            valid;
   logic                            ready;
   logic [plet_pkg::CSR_IDX_W-1:0]  index;
   logic [plet_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/plet_front.sv -----
// front end: accepts bytes, holds the line parse state and limits, builds result bundles
// depends on plet_pkg and plet_if
module plet_front (
   input  logic                 clock,
   input  logic                 reset,
   plet_req_if.sink             req_bus,
   plet_csr_if.sink             csr_bus,
   input  logic                 fifo_full,
   output logic                 push,
   output plet_pkg::bundle_type push_data
);
   import plet_pkg::*;

   parse_state_type   state_ff, state_in;
   logic [SEG_W-1:0]  seg_limit_ff, seg_limit_in;
   logic [ATTR_W-1:0] attr_limit_ff, attr_limit_in;
   char_step_type     step_byte;
   char_step_type     step_nl;
   logic              add_nl;
   logic              hit_nl;
   logic              accept;

   assign req_bus.ready = !fifo_full;
   assign csr_bus.ready = 1'b1;
   assign accept = req_bus.valid && !fifo_full;

   // the byte, then the implicit newline of a final byte
   always_comb begin
      step_byte = take_char(state_ff, req_bus.byte_value, seg_limit_ff, attr_limit_ff);
      step_nl   = take_char(step_byte.st, CH_NL, seg_limit_ff, attr_limit_ff);
      add_nl    = req_bus.is_final && (req_bus.byte_value != CH_NL);
      hit_nl    = add_nl && step_nl.hit;
   end

   // bundle the results: the first word goes in the first slot
   always_comb begin
      push = accept && (step_byte.hit || hit_nl);
      push_data.pair   = step_byte.hit && hit_nl;
      push_data.first  = step_byte.hit ? step_byte.res : step_nl.res;
      push_data.second = step_nl.res;
   end

   // parse state update
   always_comb begin
      state_in = state_ff;
      if (accept)
         state_in = add_nl ? step_nl.st : step_byte.st;
   end

   // csr writes
   always_comb begin
      seg_limit_in  = seg_limit_ff;
      attr_limit_in = attr_limit_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            REG_SEGMENT_LIMIT:   seg_limit_in  = csr_bus.data[SEG_W-1:0];
            REG_ATTRIBUTE_LIMIT: attr_limit_in = csr_bus.data[ATTR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.line_kind       <= LK_NONE;
         state_ff.line_phase      <= PH_SOL;
         state_ff.escape_pending  <= 1'b0;
         state_ff.segment_length  <= '0;
         state_ff.attribute_count <= '0;
         seg_limit_ff             <= SEG_CAP;
         attr_limit_ff            <= ATTR_CAP;
      end else begin
         state_ff      <= state_in;
         seg_limit_ff  <= seg_limit_in;
         attr_limit_ff <= attr_limit_in;
      end
   end

   // two results only come from a final byte with its implicit newline
   assert property (@(posedge clock) disable iff (reset)
      (push && push_data.pair) |-> (req_bus.is_final && req_bus.byte_value != CH_NL))
      else $error("result pair without implicit newline");

endmodule

// ----- src/plet_fifo.sv -----
// short bundle queue between the front end and the back end
// depends on plet_pkg
module plet_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  plet_pkg::bundle_type push_data,
   input  logic                 pop,
   output plet_pkg::bundle_type head,
   output logic                 empty,
   output logic                 full
);
   import plet_pkg::*;

   bundle_type         mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   assign head  = mem[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == FIFO_CW'(FIFO_DEPTH));

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");

endmodule

// ----- src/plet_back.sv -----
// back end: splits bundles into result words and holds them in the output register
// depends on plet_pkg and plet_if
module plet_back (
   input  logic                 clock,
   input  logic                 reset,
   input  plet_pkg::bundle_type head,
   input  logic                 empty,
   output logic                 pop,
   plet_rsp_if.source           rsp_bus
);
   import plet_pkg::*;

   logic       valid_ff, valid_in;
   logic       half_ff, half_in;
   result_type word_ff, word_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = !empty && (!valid_ff || rsp_bus.ready);

   // pick the next word from the head bundle
   always_comb begin
      pop      = 1'b0;
      half_in  = half_ff;
      valid_in = valid_ff && !rsp_bus.ready;
      word_in  = word_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         if (head.pair && !half_ff) begin
            word_in = head.first;
            last_in = 1'b0;
            half_in = 1'b1;
         end else begin
            word_in = half_ff ? head.second : head.first;
            last_in = 1'b1;
            half_in = 1'b0;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.event_kind   = word_ff.event_kind;
   assign rsp_bus.content_part = word_ff.content_part;
   assign rsp_bus.content_byte = word_ff.content_byte;
   assign rsp_bus.attr_total   = word_ff.attr_total;
   assign rsp_bus.last_result  = last_ff;

   // second half pending means the pair bundle is still at the head
   assert property (@(posedge clock) disable iff (reset) half_ff |-> (!empty && head.pair))
      else $error("second half pending without pair at head");

endmodule

// ----- src/pyx_line_event_tokenizer_top.sv -----
// top level of the pyx line event tokenizer
// depends on plet_pkg, plet_if, plet_front, plet_fifo, plet_back
//
// Usage:
//   req_bus carries one document byte per word with an is_final flag on the last
//   byte; a final byte that is not a newline gets an implicit newline after it.
//   rsp_bus carries the events of each byte, zero to two words, the last one of
//   a byte marked by last_result. csr_bus writes segment_limit (index 0) and
//   attribute_limit (index 1); write only while the block is idle.
// Throughput: one byte per cycle while the bundle queue is not full. A byte that causes
//   two events holds the output for its second word; the four-entry bundle queue absorbs this.
// Path: an accepted byte's bundle is written into a queue entry, and when the output
//   is free the output register then loads the first result word from the queue head.
// Reset: synchronous; the parse state clears to start of line, the limits go
//   to their maxima (8191 and 63) and the queue empties. No clearing pass.
// Stall: when rsp_bus.ready is low the output word holds; bytes keep being
//   taken until the queue fills, then req_bus.ready drops.
module pyx_line_event_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   plet_req_if.sink   req_bus,
   plet_rsp_if.source rsp_bus,
   plet_csr_if.sink   csr_bus
);
   import plet_pkg::*;

   logic       push;
   bundle_type push_data;
   logic       pop;
   bundle_type head;
   logic       empty;
   logic       full;

   plet_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .fifo_full (full),
      .push      (push),
      .push_data (push_data)
   );

   plet_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   plet_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .empty   (empty),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- tb/sv/plet_event_checker.sv -----
`timescale 1ns / 1ps
// checker for the pyx line event tokenizer: predicts the events of each accepted byte and
// compares every result word in order; depends on plet_pkg and the channel interfaces in plet_if
module plet_event_checker (
   input  logic clock,
   input  logic reset,
   plet_req_if  req_bus,
   plet_rsp_if  rsp_bus,
   plet_csr_if  csr_bus,
   output int   fail_count,
   output int   pending_count
);
   import plet_pkg::*;

   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      event_kind_type    kind;
      content_part_type  part;
      logic [7:0]        value;
      logic [ATTR_W-1:0] attrs;
      logic              last;
   } token_event_type;

   // predicted parse state and limit copies
   line_kind_type     cur_kind;
   line_phase_type    cur_phase;
   logic              esc_armed;
   logic [SEG_W-1:0]  seg_count;
   logic [ATTR_W-1:0] attr_count;
   logic [SEG_W-1:0]  seg_limit;
   logic [ATTR_W-1:0] attr_limit;

   token_event_type expected_events [$];
   token_event_type byte_events [$];
   token_event_type seen;
   token_event_type want;
   int              mismatches = 0;

   function automatic void note_event(event_kind_type k, content_part_type p,
                                      logic [7:0] v, logic [ATTR_W-1:0] a);
      byte_events.push_back('{k, p, v, a, 1'b0});
   endfunction

   // content byte survives only while the segment is under its limit
   function automatic void keep_content(content_part_type p, logic [7:0] v);
      logic [SEG_W-1:0] cap;
      cap = (seg_limit > SEG_CAP) ? SEG_CAP : seg_limit;
      if (seg_count < cap) begin
         seg_count = seg_count + 1'b1;
         note_event(EV_CONTENT, p, v, '0);
      end
   endfunction

   // one character through the line tokenizer
   function automatic void tokenize_char(logic [7:0] ch);
      logic [ATTR_W-1:0] cap;
      if (ch == CH_NL && cur_phase != PH_SOL) begin
         // line end
         case (cur_kind)
            LK_END: note_event(EV_END_ELEM, PT_START_NAME, '0, '0);
            LK_ATTR: begin
               cap = (attr_limit > ATTR_CAP) ? ATTR_CAP : attr_limit;
               if (attr_count < cap)
                  attr_count = attr_count + 1'b1;
               note_event(EV_ATTR_END, PT_START_NAME, '0, '0);
            end
            LK_DATA: note_event(EV_DATA_END, PT_START_NAME, '0, '0);
            LK_PI: note_event(EV_PI_END, PT_START_NAME, '0, '0);
            LK_COMMENT: note_event(EV_COMMENT_END, PT_START_NAME, '0, '0);
            default: ;
         endcase
         seg_count = '0;
         cur_phase = PH_SOL;
      end else if (cur_phase == PH_SOL) begin
         // leading character; a pending start element closes unless more attributes follow
         seg_count = '0;
         if ((cur_kind == LK_START || cur_kind == LK_ATTR) && ch != CH_A)
            note_event(EV_START_ELEM, PT_START_NAME, '0, attr_count);
         case (ch)
            CH_LPAREN: begin
               cur_kind = LK_START;
               attr_count = '0;
            end
            CH_RPAREN: cur_kind = LK_END;
            CH_A:      cur_kind = LK_ATTR;
            CH_DASH:   cur_kind = LK_DATA;
            CH_C:      cur_kind = LK_COMMENT;
            CH_D:      cur_kind = LK_DECL;
            CH_QUEST:  cur_kind = LK_PI;
            default:   cur_kind = LK_UNKNOWN;
         endcase
         cur_phase = PH_KEY;
      end else if (!esc_armed && ch == CH_BSLASH) begin
         esc_armed = 1'b1;
      end else begin
         // content position, escape translated first
         if (esc_armed) begin
            esc_armed = 1'b0;
            if (ch == CH_N)
               ch = CH_NL;
         end
         case (cur_kind)
            LK_ATTR, LK_PI: begin
               if (cur_phase == PH_KEY && ch == CH_SPACE) begin
                  seg_count = '0;
                  cur_phase = PH_VAL;
               end else if (cur_phase == PH_KEY) begin
                  keep_content((cur_kind == LK_ATTR) ? PT_ATTR_KEY : PT_PI_TARGET, ch);
               end else begin
                  keep_content((cur_kind == LK_ATTR) ? PT_ATTR_VALUE : PT_PI_DATA, ch);
               end
            end
            LK_START:   keep_content(PT_START_NAME, ch);
            LK_END:     keep_content(PT_END_NAME, ch);
            LK_DATA:    keep_content(PT_DATA, ch);
            LK_COMMENT: keep_content(PT_COMMENT, ch);
            default: ;
         endcase
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cur_kind   = LK_NONE;
         cur_phase  = PH_SOL;
         esc_armed  = 1'b0;
         seg_count  = '0;
         attr_count = '0;
         seg_limit  = SEG_CAP;
         attr_limit = ATTR_CAP;
         expected_events.delete();
      end else begin
         // limit writes
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               REG_SEGMENT_LIMIT:   seg_limit = csr_bus.data[SEG_W-1:0];
               REG_ATTRIBUTE_LIMIT: attr_limit = csr_bus.data[ATTR_W-1:0];
               default: ;
            endcase
         end
         // accepted byte plus the implicit newline of a final byte
         if (req_bus.valid && req_bus.ready) begin
            byte_events.delete();
            tokenize_char(req_bus.byte_value);
            if (req_bus.is_final && req_bus.byte_value != CH_NL)
               tokenize_char(CH_NL);
            if (byte_events.size() > 0)
               byte_events[byte_events.size() - 1].last = 1'b1;
            foreach (byte_events[i])
               expected_events.push_back(byte_events[i]);
         end
         // result word against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.event_kind, rsp_bus.content_part, rsp_bus.content_byte,
                    rsp_bus.attr_total, rsp_bus.last_result};
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: extra word kind=%0d part=%0d byte=%02h attrs=%0d last=%0d",
                           $time, seen.kind, seen.part, seen.value, seen.attrs, seen.last);
            end else begin
               want = expected_events.pop_front();
               if (seen.kind !== want.kind || seen.part !== want.part ||
                   seen.value !== want.value || seen.attrs !== want.attrs ||
                   seen.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"%0t: word mismatch expected kind=%0d part=%0d byte=%02h ",
                               "attrs=%0d last=%0d, actual kind=%0d part=%0d byte=%02h ",
                               "attrs=%0d last=%0d"},
                              $time, want.kind, want.part, want.value, want.attrs, want.last,
                              seen.kind, seen.part, seen.value, seen.attrs, seen.last);
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_events.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// top of the pyx line event tokenizer bench: clock, reset, byte stimulus, limit writes, verdict
// depends on plet_pkg, plet_if, pyx_line_event_tokenizer_top and plet_event_checker
module testbench;
   import plet_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        idle_on;
   logic        hold_off_go;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int          fail_count;
   int          pending_count;

   plet_req_if req_bus ();
   plet_rsp_if rsp_bus ();
   plet_csr_if csr_bus ();

   pyx_line_event_tokenizer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   plet_event_checker event_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int unsigned held;
      held = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && held < HOLD_CYCLES) begin
            rsp_bus.ready <= 1'b0;
            held++;
         end else if (idle_on) begin
            rsp_bus.ready <= ($urandom_range(99) >= 24);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // one byte word, with random gaps before it while idling is on
   task automatic send_byte(input logic [7:0] value, input logic last_byte);
      if (idle_on) begin
         while ($urandom_range(99) < 24) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.byte_value <= value;
      req_bus.is_final   <= last_byte;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // one document line: a leading kind character, a short random body, usually a newline
   task automatic send_doc_line();
      logic [7:0]  line_bytes [$];
      logic [7:0]  ch;
      int unsigned pick;
      int unsigned ending;
      pick = $urandom_range(99);
      if (pick < 14) ch = CH_LPAREN;
      else if (pick < 36) ch = CH_A;
      else if (pick < 50) ch = CH_DASH;
      else if (pick < 62) ch = CH_RPAREN;
      else if (pick < 72) ch = CH_QUEST;
      else if (pick < 80) ch = CH_C;
      else if (pick < 85) ch = CH_D;
      else if (pick < 90) ch = CH_NL;
      else ch = 8'($urandom_range(255));
      line_bytes.push_back(ch);
      repeat ($urandom_range(0, 10)) begin
         pick = $urandom_range(99);
         if (pick < 8) ch = CH_BSLASH;
         else if (pick < 12) ch = CH_N;
         else if (pick < 22) ch = CH_SPACE;
         else if (pick < 30) ch = 8'($urandom_range(255));
         else ch = 8'($urandom_range(33, 126));
         line_bytes.push_back(ch);
      end
      // a few lines lean on the final flag for their newline
      ending = $urandom_range(99);
      if (ending >= 6)
         line_bytes.push_back(CH_NL);
      foreach (line_bytes[i])
         send_byte(line_bytes[i], ending < 12 && i == line_bytes.size() - 1);
   endtask

   task automatic send_lines(input int unsigned count);
      int unsigned target;
      target = items_sent + count;
      while (items_sent < target)
         send_doc_line();
   endtask

   // stop offering and let every predicted word come out
   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input logic [CSR_DATA_W-1:0] seg,
                               input logic [CSR_DATA_W-1:0] attr);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= REG_SEGMENT_LIMIT;
      csr_bus.data  <= seg;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= REG_ATTRIBUTE_LIMIT;
      csr_bus.data  <= attr;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [8:0] script [$];
      req_bus.valid      = 1'b0;
      req_bus.byte_value = '0;
      req_bus.is_final   = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_SEGMENT_LIMIT;
      csr_bus.data       = '0;
      idle_on            = 1'b1;
      hold_off_go        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines under the reset limits; bit 8 is the final flag
      script = '{
         {1'b0, CH_NL}, {1'b0, CH_NL},                                  // empty unknown line
         {1'b0, CH_LPAREN}, {1'b0, 8'hFF}, {1'b0, CH_NL},               // start name, silent end
         {1'b0, CH_A}, {1'b0, CH_BSLASH}, {1'b0, CH_SPACE},             // escaped space splits
         {1'b0, 8'h00}, {1'b0, CH_NL},
         {1'b0, CH_A}, {1'b0, 8'h6B}, {1'b0, CH_NL},                    // attribute, no space
         {1'b0, CH_QUEST}, {1'b0, CH_BSLASH}, {1'b0, CH_N},             // start element, pi
         {1'b0, CH_SPACE}, {1'b0, 8'h64}, {1'b0, CH_NL},
         {1'b0, CH_C}, {1'b0, 8'h78}, {1'b0, CH_BSLASH}, {1'b0, CH_NL}, // escape left pending
         {1'b0, CH_DASH}, {1'b0, CH_N}, {1'b0, CH_NL},                  // pending escape used
         {1'b0, CH_RPAREN}, {1'b1, 8'h65},                              // final adds newline
         {1'b0, CH_A}, {1'b1, 8'h7A}                                    // document ends in attr
      };
      foreach (script[i])
         send_byte(script[i][7:0], script[i][8]);

      // maximum limits, then an element whose attribute count saturates
      wait_for_quiet();
      write_limits(SEG_CAP, CSR_DATA_W'(ATTR_CAP));
      send_byte(CH_LPAREN, 1'b0);
      send_byte(8'h65, 1'b0);
      send_byte(CH_NL, 1'b0);
      repeat (66) begin
         send_byte(CH_A, 1'b0);
         send_byte(CH_NL, 1'b0);
      end
      send_lines(180);

      // limits of one
      wait_for_quiet();
      write_limits(CSR_DATA_W'(1), CSR_DATA_W'(1));
      send_lines(150);

      // zero limits drop every content byte and hold the count at zero
      wait_for_quiet();
      write_limits('0, '0);
      send_lines(150);

      wait_for_quiet();
      write_limits(CSR_DATA_W'(3), CSR_DATA_W'(2));
      send_lines(200);

      // random limits, junk above the attribute field
      wait_for_quiet();
      write_limits(CSR_DATA_W'($urandom_range(1, 24)),
                   {7'($urandom_range(127)), 6'($urandom_range(1, 63))});
      send_lines(250);

      // no idling, one long hold-off on the result side, then a full pause
      wait_for_quiet();
      write_limits(SEG_CAP, '1);
      idle_on     <= 1'b0;
      hold_off_go <= 1'b1;
      send_lines(250);
      wait_for_quiet();
      idle_on <= 1'b1;
      send_lines(50);

      wait_for_quiet();
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
src/plet_pkg.sv
src/plet_if.sv
src/plet_front.sv
src/plet_fifo.sv
src/plet_back.sv
src/pyx_line_event_tokenizer_top.sv
tb/sv/plet_event_checker.sv
tb/sv/testbench.sv
